/* hdl/utf8_decode_column_width_defines.svh */
// Assertion macros used by the checker of the UTF-8 column width decoder
`ifndef UTF8_DECODE_COLUMN_WIDTH_DEFINES_SVH
`define UTF8_DECODE_COLUMN_WIDTH_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define U8CW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8cw check failed");

// Check that a condition implies another in the next cycle
`define U8CW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8cw check failed");

`endif

/* hdl/utf8cw_pkg.sv */
// Types, constants and width lookup for the UTF-8 column width decoder
`timescale 1ns / 1ps

package utf8cw_pkg;

  localparam int CP_BITS   = 21;
  localparam int COL_BITS  = 2;
  localparam int TOT_BITS  = 16;
  localparam int Q_DEPTH   = 2;
  localparam int Q_IDX     = 1;
  localparam int Q_CNT     = 2;

  // Byte class masks and patterns
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_PAT   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;
  localparam logic [7:0] END_BYTE   = 8'h00;

  localparam logic [COL_BITS-1:0] COL_NARROW = 2'd1;
  localparam logic [COL_BITS-1:0] COL_WIDE   = 2'd2;
  localparam logic [COL_BITS-1:0] COL_NONE   = 2'd0;

  // What follows the optional cut-short code point of one request
  typedef enum logic [1:0] {
    SEC_NONE,
    SEC_CP,
    SEC_END
  } sec_kind_t;

  // Work for one input request: up to two result records
  typedef struct packed {
    logic               first_vld;
    logic [CP_BITS-1:0] first_cp;
    sec_kind_t          sec_kind;
    logic [CP_BITS-1:0] sec_cp;
  } work_t;

  // Display width: wide in the East Asian ranges, narrow otherwise
  function automatic logic [COL_BITS-1:0] width_of(input logic [CP_BITS-1:0] cp);
    logic wide;
    wide = cp inside {[21'h01100:21'h0115F], [21'h02E80:21'h0A4CF],
                      [21'h0AC00:21'h0D7A3], [21'h0F900:21'h0FAFF],
                      [21'h0FF00:21'h0FF60], [21'h20000:21'h3FFFD]};
    return wide ? COL_WIDE : COL_NARROW;
  endfunction

endpackage

/* hdl/utf8cw_fifo.sv */
// Two-entry work queue between the byte classifier and the result stage
`timescale 1ns / 1ps

module utf8cw_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  utf8cw_pkg::work_t push_data,
  input  logic             pop,
  output utf8cw_pkg::work_t head,
  output logic             not_empty,
  output logic             full
);
  import utf8cw_pkg::*;

  work_t             slots [Q_DEPTH];
  logic [Q_IDX-1:0]  wr_ptr;
  logic [Q_IDX-1:0]  rd_ptr;
  logic [Q_CNT-1:0]  count;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == Q_CNT'(Q_DEPTH));

  // Store pushed work
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/utf8cw_front.sv */
// Byte classifier: tracks open sequences and queues the records each byte causes
`timescale 1ns / 1ps

module utf8cw_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  text_byte,
  input  logic                        q_full,
  output logic                        push,
  output utf8cw_pkg::work_t           push_data
);
  import utf8cw_pkg::*;

  logic [1:0]         bytes_still_expected;
  logic [1:0]         bytes_still_expected_next;
  logic [CP_BITS-1:0] partial_code_point;
  logic [CP_BITS-1:0] partial_code_point_next;
  logic               accept;
  logic               is_cont;
  logic [CP_BITS-1:0] shifted_cp;
  work_t              work;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_cont  = ((text_byte & CONT_MASK) == CONT_PAT);
  assign shifted_cp = {partial_code_point[CP_BITS-7:0], text_byte[5:0]};

  // Classify the byte and build its work
  always_comb begin
    bytes_still_expected_next = bytes_still_expected;
    partial_code_point_next   = partial_code_point;
    work.first_vld = 1'b0;
    work.first_cp  = partial_code_point;
    work.sec_kind  = SEC_NONE;
    work.sec_cp    = CP_BITS'(text_byte);
    if (bytes_still_expected != 2'd0 && is_cont) begin
      // Gather six payload bits; emit when complete
      bytes_still_expected_next = bytes_still_expected - 2'd1;
      partial_code_point_next   = shifted_cp;
      if (bytes_still_expected == 2'd1) begin
        work.sec_kind           = SEC_CP;
        work.sec_cp             = shifted_cp;
        partial_code_point_next = '0;
      end
    end else begin
      // Flush a cut-short sequence, then handle the byte anew
      work.first_vld            = (bytes_still_expected != 2'd0);
      bytes_still_expected_next = 2'd0;
      partial_code_point_next   = '0;
      if (text_byte == END_BYTE) begin
        work.sec_kind = SEC_END;
      end else if ((text_byte & LEAD2_MASK) == LEAD2_PAT) begin
        bytes_still_expected_next = 2'd1;
        partial_code_point_next   = CP_BITS'(text_byte[4:0]);
      end else if ((text_byte & LEAD3_MASK) == LEAD3_PAT) begin
        bytes_still_expected_next = 2'd2;
        partial_code_point_next   = CP_BITS'(text_byte[3:0]);
      end else if ((text_byte & LEAD4_MASK) == LEAD4_PAT) begin
        bytes_still_expected_next = 2'd3;
        partial_code_point_next   = CP_BITS'(text_byte[2:0]);
      end else begin
        work.sec_kind = SEC_CP;
      end
    end
  end

  assign push      = accept && (work.first_vld || work.sec_kind != SEC_NONE);
  assign push_data = work;

  // Hold sequence state between bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_still_expected <= 2'd0;
      partial_code_point   <= '0;
    end else if (accept) begin
      bytes_still_expected <= bytes_still_expected_next;
      partial_code_point   <= partial_code_point_next;
    end
  end

endmodule

/* hdl/utf8cw_back.sv */
// Result stage: sizes each code point, keeps the column sum, drives the output register
`timescale 1ns / 1ps

module utf8cw_back #(
  parameter int SUM_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  utf8cw_pkg::work_t                      head,
  input  logic                                   q_not_empty,
  output logic                                   pop,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [utf8cw_pkg::CP_BITS-1:0]         code_point,
  output logic [utf8cw_pkg::COL_BITS-1:0]        columns,
  output logic                                   end_of_text,
  output logic [utf8cw_pkg::TOT_BITS-1:0]        total_columns,
  output logic                                   last_of_run
);
  import utf8cw_pkg::*;

  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  logic                phase;
  logic [SUM_BITS-1:0] column_sum;
  logic [SUM_BITS-1:0] column_sum_next;
  logic                load;
  logic                use_first;
  logic                rec_end;
  logic                rec_last;
  logic [CP_BITS-1:0]  rec_cp;
  logic [COL_BITS-1:0] rec_cols;
  logic [SUM_BITS:0]   sum_wide;
  logic [SUM_BITS-1:0] sum_sat;
  logic [31:0]         total32;

  // Pick the record at hand from the head work
  assign use_first = head.first_vld && !phase;
  assign rec_end   = !use_first && (head.sec_kind == SEC_END);
  assign rec_last  = !use_first || (head.sec_kind == SEC_NONE);
  assign rec_cp    = use_first ? head.first_cp : head.sec_cp;
  assign rec_cols  = rec_end ? COL_NONE : width_of(rec_cp);

  // Add the width, saturating at the top of the sum
  assign sum_wide = {1'b0, column_sum} + (SUM_BITS + 1)'(rec_cols);
  assign sum_sat  = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
  assign total32  = rec_end ? 32'(column_sum) : 32'(sum_sat);
  assign column_sum_next = rec_end ? '0 : sum_sat;

  assign load = q_not_empty && (!out_valid || !out_stall);
  assign pop  = load && rec_last;

  // Load the output payload
  always_ff @(posedge clk) begin
    if (load) begin
      code_point    <= rec_end ? '0 : rec_cp;
      columns       <= rec_cols;
      end_of_text   <= rec_end;
      total_columns <= total32[TOT_BITS-1:0];
      last_of_run   <= rec_last;
    end
  end

  // Advance control state and the column sum
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      phase      <= 1'b0;
      column_sum <= '0;
    end else begin
      if (load) begin
        out_valid  <= 1'b1;
        phase      <= !rec_last;
        column_sum <= column_sum_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/utf8_decode_column_width.sv */
// Top level of the lenient UTF-8 decoder with display column counting
//
// Input channel: one text byte per request on text_byte, qualified by in_valid
// and held back by in_stall. A zero byte ends the text.
// Output channel: one record per request on code_point, columns, end_of_text,
// total_columns and last_of_run, qualified by out_valid, held by out_stall.
// A byte causes zero, one or two records; last_of_run marks the final one.
// A record reaches the output by way of the work queue, which the classifier
// writes when it accepts the byte that causes the record, and then the output
// register; the second record of a byte follows the first.
// Throughput: one byte per cycle while in_stall is low; a byte that causes
// two records holds the output register for each in turn. in_stall follows
// the two-entry work queue: it asserts while both entries are held, which
// happens when the output side stalls or when a byte that causes two records
// is followed at once by a byte that causes a record.
// Reset clears the open sequence, the column sum, the queue and out_valid.
// While out_valid and out_stall are high the output record holds and the
// queue fills; the classifier keeps taking bytes until the queue is full.
`timescale 1ns / 1ps

module utf8_decode_column_width #(
  parameter int SUM_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          text_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [utf8cw_pkg::CP_BITS-1:0]      code_point,
  output logic [utf8cw_pkg::COL_BITS-1:0]     columns,
  output logic                                end_of_text,
  output logic [utf8cw_pkg::TOT_BITS-1:0]     total_columns,
  output logic                                last_of_run
);
  import utf8cw_pkg::*;

  logic  push;
  work_t push_data;
  logic  pop;
  work_t head;
  logic  q_not_empty;
  logic  q_full;

  // Classify incoming bytes
  utf8cw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .text_byte (text_byte),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Queue work between the two sides
  utf8cw_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Produce records
  utf8cw_back #(
    .SUM_BITS (SUM_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_not_empty   (q_not_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .code_point    (code_point),
    .columns       (columns),
    .end_of_text   (end_of_text),
    .total_columns (total_columns),
    .last_of_run   (last_of_run)
  );

endmodule

/* hdl/utf8cw_checker.sv */
// Port-level checks for the UTF-8 column width decoder, bound to the top level
`timescale 1ns / 1ps
`include "utf8_decode_column_width_defines.svh"

module utf8cw_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [7:0]                      text_byte,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [utf8cw_pkg::CP_BITS-1:0]  code_point,
  input logic [utf8cw_pkg::COL_BITS-1:0] columns,
  input logic                            end_of_text,
  input logic [utf8cw_pkg::TOT_BITS-1:0] total_columns,
  input logic                            last_of_run
);
  import utf8cw_pkg::*;

  // Hold a stalled input request
  `U8CW_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(text_byte))

  // Hold a stalled record
  `U8CW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(code_point) && $stable(total_columns))

  // End record carries no code point and no width
  `U8CW_ASSERT_NOW(a_end_empty, out_valid && end_of_text, code_point == '0 && columns == COL_NONE)

  // End record closes its byte's run
  `U8CW_ASSERT_NOW(a_end_last, out_valid && end_of_text, last_of_run)

  // Code point records are narrow or wide
  `U8CW_ASSERT_NOW(a_cp_width, out_valid && !end_of_text, columns == COL_NARROW || columns == COL_WIDE)

endmodule

bind utf8_decode_column_width utf8cw_checker u_checker (.*);
